FILE: sv/ready_queue_with_removal_unit_macros.svh
// Assertion macros shared by the ready queue RTL.
`ifndef READY_QUEUE_WITH_REMOVAL_UNIT_MACROS_SVH
`define READY_QUEUE_WITH_REMOVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define RQR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rqr: implication check failed");

// Next-cycle implication.
`define RQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rqr: next-cycle check failed");

`else

`define RQR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RQR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/rqr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 4;
    localparam int OPCODE_W        = 2;
    localparam int COUNT_W         = 5;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // update the cells and the result register
    } t_dp_cmd;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               queue_empty;
        logic               was_queued;
        logic               popped_valid;
        logic [ID_W-1:0]    popped_id;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

FILE: sv/rqr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rqr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rqr_pkg::t_dp_cmd o_cmd
);

    rqr_pkg::t_state r_state;
    rqr_pkg::t_state n_state;
    logic            r_out_vld;
    logic            n_out_vld;
    logic            w_slot_free;

    assign w_slot_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rqr_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rqr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rqr_pkg::ST_EXEC;
                end
            end
            rqr_pkg::ST_EXEC: begin
                if (w_slot_free) begin
                    n_state = rqr_pkg::ST_IDLE;
                end
            end
            default: n_state = rqr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        n_out_vld  = r_out_vld && !i_out_ready;
        unique case (r_state)
            rqr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rqr_pkg::ST_EXEC: begin
                // hold the request until the result register can take it
                if (w_slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_out_vld  = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

FILE: sv/rqr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rqr_datapath #(
    parameter int QUEUE_DEPTH = rqr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rqr_pkg::t_dp_cmd           i_cmd,
    input  rqr_pkg::t_opcode           i_opcode,
    input  logic [rqr_pkg::ID_W-1:0]   i_thread_id,
    output rqr_pkg::t_result           o_result
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rqr_pkg::t_opcode           r_op;
    logic [rqr_pkg::ID_W-1:0]   r_tid;
    logic [rqr_pkg::ID_W-1:0]   r_slot_id [QUEUE_DEPTH];
    logic [rqr_pkg::ID_W-1:0]   n_slot_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]     r_slot_vld;
    logic [QUEUE_DEPTH-1:0]     n_slot_vld;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    rqr_pkg::t_result           r_result;
    rqr_pkg::t_result           n_result;

    logic [rqr_pkg::ID_W-1:0]   w_up_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]     w_up_vld;
    logic [QUEUE_DEPTH-1:0]     w_match;
    logic                       w_hit;
    logic [IDX_W-1:0]           w_pos;
    logic [IDX_W-1:0]           w_drop_pos;
    logic                       w_is_pop;
    logic                       w_is_find;
    logic                       w_pop_ok;
    logic                       w_drop;
    logic                       w_append;
    logic [CNT_W-1:0]           w_cnt_mid;

    // Each cell sees its upper neighbor; the top cell takes an empty slot.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g < QUEUE_DEPTH - 1) begin : g_inner
            assign w_up_id[g]  = r_slot_id[g+1];
            assign w_up_vld[g] = r_slot_vld[g+1];
        end else begin : g_top
            assign w_up_id[g]  = '0;
            assign w_up_vld[g] = 1'b0;
        end
        assign w_match[g] = r_slot_vld[g] && (r_slot_id[g] == r_tid);
    end

    assign w_hit = |w_match;

    // Identifiers are unique in the queue, so at most one cell matches.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_is_pop   = (r_op == rqr_pkg::OP_POP);
    assign w_is_find  = (r_op == rqr_pkg::OP_PUSH) || (r_op == rqr_pkg::OP_REMOVE);
    assign w_pop_ok   = w_is_pop && r_slot_vld[0];
    assign w_drop     = w_is_find ? w_hit : w_pop_ok;
    assign w_drop_pos = w_is_pop ? '0 : w_pos;
    assign w_cnt_mid  = r_count - CNT_W'(w_drop);
    assign w_append   = (r_op == rqr_pkg::OP_PUSH) && (w_cnt_mid < CNT_W'(QUEUE_DEPTH));
    assign n_count    = w_cnt_mid + CNT_W'(w_append);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            // close the gap: every cell at or above the dropped one shifts down
            if (w_drop && (IDX_W'(i) >= w_drop_pos)) begin
                n_slot_id[i]  = w_up_id[i];
                n_slot_vld[i] = w_up_vld[i];
            end else begin
                n_slot_id[i]  = r_slot_id[i];
                n_slot_vld[i] = r_slot_vld[i];
            end
            if (w_append && (CNT_W'(i) == w_cnt_mid)) begin
                n_slot_id[i]  = r_tid;
                n_slot_vld[i] = 1'b1;
            end
        end
    end

    always_comb begin
        n_result              = '0;
        n_result.popped_id    = w_pop_ok ? r_slot_id[0] : '0;
        n_result.popped_valid = w_pop_ok;
        n_result.was_queued   = w_is_find && w_hit;
        n_result.queue_empty  = (n_count == '0);
        n_result.entry_count  = rqr_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_count    <= '0;
        end else if (i_cmd.exec) begin
            r_slot_vld <= n_slot_vld;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_tid <= i_thread_id;
        end
        if (i_cmd.exec) begin
            r_slot_id <= n_slot_id;
            r_result  <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: sv/ready_queue_with_removal_unit.sv
// Ready queue of 4-bit thread identifiers with push, pop and remove-by-id.
// A request is first captured; then comes the update, in which every queue
// cell compares its identifier against the request at once and the cells
// above a removed entry shift down by one. The next request is accepted in
// the cycle after the update, and none is taken while one is in flight;
// a stalled result register holds the update back.
// Input tdata: opcode [1:0] (0 push, 1 pop, 2 remove, 3 no operation),
// thread_id [5:2]. A push of a queued identifier moves it to the tail.
`timescale 1ns / 1ps
`default_nettype none

`include "ready_queue_with_removal_unit_macros.svh"

module ready_queue_with_removal_unit #(
    parameter int QUEUE_DEPTH = rqr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode [1:0], thread_id [5:2], zero [7:6]
    input  logic [rqr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // popped_id [3:0], popped_valid [4], was_queued [5], queue_empty [6],
    // entry_count [11:7], zero [15:12]
    output logic [rqr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    rqr_pkg::t_dp_cmd w_cmd;
    rqr_pkg::t_result w_result;

    rqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    rqr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_opcode    (rqr_pkg::t_opcode'(s_axis_tdata[rqr_pkg::OPCODE_W-1:0])),
        .i_thread_id (s_axis_tdata[rqr_pkg::OPCODE_W +: rqr_pkg::ID_W]),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {{(rqr_pkg::OUT_TDATA_W - rqr_pkg::RESULT_W){1'b0}}, w_result};

    `RQR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RQR_ASSERT_IMPL(a_empty_count_zero, i_clk, i_rst_n, m_axis_tvalid && w_result.queue_empty, w_result.entry_count == '0)
    `RQR_ASSERT_IMPL(a_pop_not_found, i_clk, i_rst_n, m_axis_tvalid && w_result.popped_valid, !w_result.was_queued)
    `RQR_ASSERT_IMPL(a_id_only_on_pop, i_clk, i_rst_n, m_axis_tvalid && !w_result.popped_valid, w_result.popped_id == '0)

endmodule

`default_nettype wire
